// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the sequencer modules. Expects clk and
// rst_n in the scope of use.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mcs_pkg.sv =====
// ----------------------------------------------------------------------------
// mcs_pkg
// Shared types, command codes and the note period table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcs_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PERIOD_W   = 11;
  localparam int unsigned TAB_IDX_W  = 7;   // 128-entry table space
  localparam int unsigned TABLE_CAP  = 128;
  localparam int unsigned DIV_W      = 12;  // dividend / quotient width
  localparam int unsigned DIV_STEPS  = 12;
  localparam int unsigned DIV_CNT_W  = 4;

  localparam logic [BYTE_W-1:0] CMD_NOTE_MAX = 8'd11;
  localparam logic [BYTE_W-1:0] CMD_OCTAVE   = 8'd12;
  localparam logic [BYTE_W-1:0] CMD_TEMPO    = 8'd22;
  localparam logic [BYTE_W-1:0] CMD_VOLUME   = 8'd24;
  localparam logic [BYTE_W-1:0] CMD_REST     = 8'd25;
  localparam logic [BYTE_W-1:0] CMD_LOOP     = 8'd254;
  localparam logic [BYTE_W-1:0] ARG_DOWN     = 8'd13;
  localparam logic [BYTE_W-1:0] ARG_UP       = 8'd14;

  localparam logic [DIV_W-1:0]  WAIT_NUMERATOR = 12'd3600;
  localparam logic [BYTE_W-1:0] WAIT_MAX       = 8'hff;
  localparam logic [BYTE_W-1:0] TRIGGER_BIT    = 8'h80;

  localparam logic [BYTE_W-1:0] RESET_OCTAVE = 8'd4;
  localparam logic [BYTE_W-1:0] RESET_TEMPO  = 8'd60;
  localparam logic [3:0]        RESET_VOLUME = 4'd8;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_NOTE    = 2'd1,
    ACT_REST    = 2'd2,
    ACT_RESTART = 2'd3
  } action_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // latch the incoming item
    logic decode;     // evaluate command, update song state
    logic start1;     // 3600 / tempo
    logic start2;     // quotient / length
    logic wait_load;  // take final quotient into wait
    logic load_out;   // move result into output register
  } mcs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_div;
    logic div_done;
  } mcs_status_t;

  function automatic logic [PERIOD_W-1:0] note_period(input logic [TAB_IDX_W-1:0] idx);
    logic [PERIOD_W-1:0] p;
    case (idx)
      7'd0:  p = 11'd44;   7'd1:  p = 11'd156;  7'd2:  p = 11'd262;  7'd3:  p = 11'd363;
      7'd4:  p = 11'd457;  7'd5:  p = 11'd547;  7'd6:  p = 11'd631;  7'd7:  p = 11'd710;
      7'd8:  p = 11'd786;  7'd9:  p = 11'd854;  7'd10: p = 11'd923;  7'd11: p = 11'd986;
      7'd12: p = 11'd1046; 7'd13: p = 11'd1102; 7'd14: p = 11'd1155; 7'd15: p = 11'd1205;
      7'd16: p = 11'd1253; 7'd17: p = 11'd1297; 7'd18: p = 11'd1339; 7'd19: p = 11'd1379;
      7'd20: p = 11'd1417; 7'd21: p = 11'd1452; 7'd22: p = 11'd1486; 7'd23: p = 11'd1517;
      7'd24: p = 11'd1546; 7'd25: p = 11'd1575; 7'd26: p = 11'd1602; 7'd27: p = 11'd1627;
      7'd28: p = 11'd1650; 7'd29: p = 11'd1673; 7'd30: p = 11'd1694; 7'd31: p = 11'd1714;
      7'd32: p = 11'd1732; 7'd33: p = 11'd1750; 7'd34: p = 11'd1767; 7'd35: p = 11'd1783;
      7'd36: p = 11'd1798; 7'd37: p = 11'd1812; 7'd38: p = 11'd1825; 7'd39: p = 11'd1837;
      7'd40: p = 11'd1849; 7'd41: p = 11'd1860; 7'd42: p = 11'd1871; 7'd43: p = 11'd1881;
      7'd44: p = 11'd1890; 7'd45: p = 11'd1899; 7'd46: p = 11'd1907; 7'd47: p = 11'd1915;
      7'd48: p = 11'd1923; 7'd49: p = 11'd1930; 7'd50: p = 11'd1936; 7'd51: p = 11'd1943;
      7'd52: p = 11'd1949; 7'd53: p = 11'd1954; 7'd54: p = 11'd1959; 7'd55: p = 11'd1964;
      7'd56: p = 11'd1969; 7'd57: p = 11'd1974; 7'd58: p = 11'd1978; 7'd59: p = 11'd1982;
      7'd60: p = 11'd1985; 7'd61: p = 11'd1988; 7'd62: p = 11'd1992; 7'd63: p = 11'd1995;
      7'd64: p = 11'd1998; 7'd65: p = 11'd2001; 7'd66: p = 11'd2004; 7'd67: p = 11'd2006;
      7'd68: p = 11'd2009; 7'd69: p = 11'd2011; 7'd70: p = 11'd2013; 7'd71: p = 11'd2015;
      default: p = '0;   // slack above the built-in entries
    endcase
    return p;
  endfunction

endpackage

// ===== design/mcs_divider.sv =====
// ----------------------------------------------------------------------------
// mcs_divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcs_divider
  import mcs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DIV_W-1:0]    dividend,
  input  logic [BYTE_W-1:0]   divisor,    // nonzero at start
  output logic                busy,
  output logic                done,       // one-cycle pulse, quotient final
  output logic [DIV_W-1:0]    quotient
);

  logic [DIV_W-1:0]     dvd_r, dvd_nxt;
  logic [BYTE_W-1:0]    rem_r, rem_nxt;
  logic [BYTE_W-1:0]    dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [BYTE_W:0]      trial;
  logic                 ge;

  assign trial = {rem_r, dvd_r[DIV_W-1]};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? BYTE_W'(trial - {1'b0, dvs_r}) : trial[BYTE_W-1:0];
      dvd_nxt = {dvd_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

// ===== design/mcs_datapath.sv =====
// ----------------------------------------------------------------------------
// mcs_datapath
// Song state, command decode, period lookup, wait division, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcs_datapath
  import mcs_pkg::*;
#(
  parameter int unsigned NOTE_TABLE_DEPTH = 72
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [BYTE_W-1:0] in_command,
  input  logic [BYTE_W-1:0] in_argument,
  input  mcs_cmd_t          cmd,
  output mcs_status_t       status,
  output logic [1:0]        out_action,
  output logic [BYTE_W-1:0] out_envelope_value,
  output logic [BYTE_W-1:0] out_period_low,
  output logic [BYTE_W-1:0] out_period_high_trigger,
  output logic [BYTE_W-1:0] out_wait_ticks,
  output logic              out_index_fault
);

  localparam logic [DIV_W-1:0] DEPTH_LIM = DIV_W'(NOTE_TABLE_DEPTH);

  logic [BYTE_W-1:0] cmd_r, arg_r;
  logic [BYTE_W-1:0] octave_r, octave_nxt;
  logic [BYTE_W-1:0] tempo_r, tempo_nxt;
  logic [3:0]        volume_r, volume_nxt;

  // working result
  action_t           act_r, act_nxt;
  logic [BYTE_W-1:0] env_r, env_nxt;
  logic [BYTE_W-1:0] plo_r, plo_nxt;
  logic [BYTE_W-1:0] phi_r, phi_nxt;
  logic [BYTE_W-1:0] wait_r, wait_nxt;
  logic              flt_r, flt_nxt;

  // output register
  logic [1:0]        o_act_r;
  logic [BYTE_W-1:0] o_env_r, o_plo_r, o_phi_r, o_wait_r;
  logic              o_flt_r;

  logic                  is_note;
  logic signed [12:0]    oct_off, idx_s;
  logic                  note_fault;
  logic [PERIOD_W-1:0]   period;
  logic                  wants_wait;

  logic                  div_start;
  logic [DIV_W-1:0]      div_dividend;
  logic [BYTE_W-1:0]     div_divisor;
  logic                  div_busy, div_done;
  logic [DIV_W-1:0]      div_q;

  // note index = (octave - 3) * 12 + note
  assign is_note    = cmd_r inside {[8'd0:CMD_NOTE_MAX]};
  assign oct_off    = $signed({5'b0, octave_r}) - 13'sd3;
  assign idx_s      = (oct_off <<< 3) + (oct_off <<< 2) + $signed({9'b0, cmd_r[3:0]});
  assign note_fault = idx_s[12] || (idx_s[DIV_W-1:0] >= DEPTH_LIM);
  assign period     = note_period(idx_s[TAB_IDX_W-1:0]);
  assign wants_wait = (is_note && !note_fault) || (cmd_r == CMD_REST);

  always_comb begin
    octave_nxt = octave_r;
    tempo_nxt  = tempo_r;
    volume_nxt = volume_r;
    act_nxt    = act_r;
    env_nxt    = env_r;
    plo_nxt    = plo_r;
    phi_nxt    = phi_r;
    wait_nxt   = wait_r;
    flt_nxt    = flt_r;
    if (cmd.decode) begin
      act_nxt  = ACT_NONE;
      env_nxt  = '0;
      plo_nxt  = '0;
      phi_nxt  = '0;
      flt_nxt  = 1'b0;
      // zero tempo or length: wait pinned to max, divider skipped
      wait_nxt = wants_wait ? WAIT_MAX : '0;
      if (is_note) begin
        if (note_fault) begin
          flt_nxt = 1'b1;
        end else begin
          act_nxt = ACT_NOTE;
          env_nxt = {volume_r, 4'd7};
          plo_nxt = period[7:0];
          phi_nxt = TRIGGER_BIT | {5'b0, period[PERIOD_W-1:8]};
        end
      end else begin
        case (cmd_r)
          CMD_OCTAVE: begin
            if (arg_r == ARG_DOWN)    octave_nxt = octave_r - 1'b1;
            else if (arg_r == ARG_UP) octave_nxt = octave_r + 1'b1;
            else                      octave_nxt = arg_r;
          end
          CMD_TEMPO:  tempo_nxt  = arg_r;
          CMD_VOLUME: volume_nxt = arg_r[3:0];
          CMD_REST:   act_nxt    = ACT_REST;
          CMD_LOOP:   act_nxt    = ACT_RESTART;
          default: ;
        endcase
      end
    end
    if (cmd.wait_load) begin
      wait_nxt = (|div_q[DIV_W-1:BYTE_W]) ? WAIT_MAX : div_q[BYTE_W-1:0];
    end
  end

  assign div_start    = cmd.start1 || cmd.start2;
  assign div_dividend = cmd.start1 ? WAIT_NUMERATOR : div_q;
  assign div_divisor  = cmd.start1 ? tempo_r : arg_r;

  mcs_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign status.need_div = wants_wait && (tempo_r != '0) && (arg_r != '0);
  assign status.div_done = div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_r <= RESET_OCTAVE;
      tempo_r  <= RESET_TEMPO;
      volume_r <= RESET_VOLUME;
    end else begin
      octave_r <= octave_nxt;
      tempo_r  <= tempo_nxt;
      volume_r <= volume_nxt;
    end
    if (cmd.capture) begin
      cmd_r <= in_command;
      arg_r <= in_argument;
    end
    act_r  <= act_nxt;
    env_r  <= env_nxt;
    plo_r  <= plo_nxt;
    phi_r  <= phi_nxt;
    wait_r <= wait_nxt;
    flt_r  <= flt_nxt;
    if (cmd.load_out) begin
      o_act_r  <= act_r;
      o_env_r  <= env_r;
      o_plo_r  <= plo_r;
      o_phi_r  <= phi_r;
      o_wait_r <= wait_r;
      o_flt_r  <= flt_r;
    end
  end

  assign out_action              = o_act_r;
  assign out_envelope_value      = o_env_r;
  assign out_period_low          = o_plo_r;
  assign out_period_high_trigger = o_phi_r;
  assign out_wait_ticks          = o_wait_r;
  assign out_index_fault         = o_flt_r;

`include "assert_macros.svh"

  `MCS_ASSERT_IMP(a_div_start_idle, div_start, !div_busy, "divider restarted while busy")
  `MCS_ASSERT_IMP(a_div_divisor_nz, div_start, div_divisor != '0, "divider started on zero")
  `MCS_ASSERT_NXT(a_wait_fault, cmd.decode && is_note && note_fault, wait_r == '0 && flt_r,
                  "faulted note carries a wait")

endmodule

// ===== design/mcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcs_ctrl
// Sequencer for capture, decode, two chained divisions and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcs_ctrl
  import mcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  mcs_status_t status,
  output mcs_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_DIV1   = 5'b00100,
    S_DIV2   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        if (status.need_div) begin
          cmd.start1 = 1'b1;
          state_nxt  = S_DIV1;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_DIV1: begin
        if (status.div_done) begin
          cmd.start2 = 1'b1;
          state_nxt  = S_DIV2;
        end
      end
      S_DIV2: begin
        if (status.div_done) begin
          cmd.wait_load = 1'b1;
          state_nxt     = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`include "assert_macros.svh"

  `MCS_ASSERT_IMP(a_no_overwrite, cmd.load_out, !out_valid_r || out_ready,
                  "pending result overwritten")
  `MCS_ASSERT_NXT(a_load_sets_valid, cmd.load_out, out_valid_r, "loaded result not shown")
  `MCS_ASSERT_IMP(a_done_in_div, status.div_done, state_r == S_DIV1 || state_r == S_DIV2,
                  "divider finished outside a divide state")

endmodule

// ===== design/music_command_sequencer_core.sv =====
// Steps: accept, decode, finish for commands without a wait, or with a zero tempo
//   or length; a note or rest that divides adds two serial divides (3600/tempo,
//   then /length) between decode and finish. One item at a time; finish holds
//   while the previous result is still pending.
//   in_ready is high only between items.
// Reset: rst_n synchronous, active low; octave 4, tempo 60, volume 8, no result.
// ----------------------------------------------------------------------------
// music_command_sequencer_core
// Song command decoder: note period lookup, envelope and wait tick output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module music_command_sequencer_core
  import mcs_pkg::*;
#(
  parameter int unsigned NOTE_TABLE_DEPTH = 72   // 12..128
) (
  input  logic              clk,
  input  logic              rst_n,
  // command item
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_command,
  input  logic [BYTE_W-1:0] in_argument,
  // result item
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_action,
  output logic [BYTE_W-1:0] out_envelope_value,
  output logic [BYTE_W-1:0] out_period_low,
  output logic [BYTE_W-1:0] out_period_high_trigger,
  output logic [BYTE_W-1:0] out_wait_ticks,
  output logic              out_index_fault
);

  // Controller drives per-state strobes; datapath reports whether the
  // wait needs dividing and when each division has finished.
  mcs_cmd_t    dp_cmd;
  mcs_status_t dp_status;

  // The result register sits in the datapath, so a new item can be decoded
  // and divided while the previous result still waits for out_ready; the
  // controller holds in its finish state only if that result is still pending.
  mcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (dp_status),
    .cmd       (dp_cmd)
  );

  // Note index (octave-3)*12+note checked against NOTE_TABLE_DEPTH; a miss
  // gives the fault flag and an otherwise empty result.
  mcs_datapath #(
    .NOTE_TABLE_DEPTH (NOTE_TABLE_DEPTH)
  ) u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_command              (in_command),
    .in_argument             (in_argument),
    .cmd                     (dp_cmd),
    .status                  (dp_status),
    .out_action              (out_action),
    .out_envelope_value      (out_envelope_value),
    .out_period_low          (out_period_low),
    .out_period_high_trigger (out_period_high_trigger),
    .out_wait_ticks          (out_wait_ticks),
    .out_index_fault         (out_index_fault)
  );

endmodule

// ===== tb/music_command_sequencer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// music_command_sequencer_core_tb
// Drives song command items into the sequencer core, predicts each result
// item from a local copy of octave, tempo and volume, and checks every
// result field in order. Directed corner items first, then random songs
// with idle and stall bursts on both channels.
// ----------------------------------------------------------------------------

module music_command_sequencer_core_tb
  import mcs_pkg::*;
;

  localparam int NOTE_DEPTH    = 72;
  localparam int BUILTIN_NOTES = 72;
  localparam int RANDOM_ITEMS  = 1600;
  localparam int QUIET_ITEMS   = 150;    // tail of the run with no idling
  localparam int DRAIN_CYCLES  = 40;     // well past the dividing path

  // Two command bytes with no meaning, used as noise in the directed part.
  localparam logic [BYTE_W-1:0] CMD_UNKNOWN_HI = 8'd255;
  localparam logic [BYTE_W-1:0] CMD_UNKNOWN_LO = 8'd13;

  // One pending command item. drain: hold it back until every result is in.
  // quiet: no idling from here on.
  typedef struct {
    logic [BYTE_W-1:0] command;
    logic [BYTE_W-1:0] argument;
    bit                drain;
    bit                quiet;
  } song_cmd_t;

  typedef struct packed {
    action_t           action;
    logic [BYTE_W-1:0] envelope;
    logic [BYTE_W-1:0] period_low;
    logic [BYTE_W-1:0] period_high;
    logic [BYTE_W-1:0] ticks;
    logic              fault;
  } song_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_command = '0;
  logic [BYTE_W-1:0] in_argument = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_action;
  logic [BYTE_W-1:0] out_envelope_value;
  logic [BYTE_W-1:0] out_period_low;
  logic [BYTE_W-1:0] out_period_high_trigger;
  logic [BYTE_W-1:0] out_wait_ticks;
  logic              out_index_fault;

  song_cmd_t    song_commands[$];     // items not yet offered
  song_result_t results_due[$];       // predicted results, oldest first

  // Song state as the block should hold it.
  logic [BYTE_W-1:0]   octave_now;
  logic [BYTE_W-1:0]   tempo_now;
  logic [3:0]          volume_now;
  logic [PERIOD_W-1:0] tone_period [0:BUILTIN_NOTES-1];

  logic in_fire = 1'b0;     // item taken at the last rising edge
  bit   calm = 1'b0;        // idling switched off for the tail
  int   gap_left = 0;
  int   stall_left = 0;
  int   mismatch_count = 0;

  music_command_sequencer_core #(
    .NOTE_TABLE_DEPTH(NOTE_DEPTH)
  ) i_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_command              (in_command),
    .in_argument             (in_argument),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_action              (out_action),
    .out_envelope_value      (out_envelope_value),
    .out_period_low          (out_period_low),
    .out_period_high_trigger (out_period_high_trigger),
    .out_wait_ticks          (out_wait_ticks),
    .out_index_fault         (out_index_fault)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // 3600 / tempo / length, saturated; a zero divisor gives the maximum.
  function automatic logic [BYTE_W-1:0] wait_for_length(input logic [BYTE_W-1:0] len);
    int q;
    if (tempo_now == 0 || len == 0) return WAIT_MAX;
    q = (int'(WAIT_NUMERATOR) / int'(tempo_now)) / int'(len);
    return (q > int'(WAIT_MAX)) ? WAIT_MAX : q[BYTE_W-1:0];
  endfunction

  // Works out the result of one command and steps the song state.
  function automatic song_result_t play_command(input logic [BYTE_W-1:0] cmd,
                                                input logic [BYTE_W-1:0] arg);
    song_result_t        r;
    int                  idx;
    logic [PERIOD_W-1:0] period;
    r = '0;
    r.action = ACT_NONE;
    if (cmd <= CMD_NOTE_MAX) begin
      idx = (int'(octave_now) - 3) * 12 + int'(cmd);
      if (idx < 0 || idx >= NOTE_DEPTH) begin
        // outside the table: fault only, nothing played
        r.fault = 1'b1;
      end else begin
        period        = (idx < BUILTIN_NOTES) ? tone_period[idx] : '0;
        r.action      = ACT_NOTE;
        r.envelope    = {volume_now, 4'h7};
        r.period_low  = period[7:0];
        r.period_high = TRIGGER_BIT | {5'd0, period[10:8]};
        r.ticks       = wait_for_length(arg);
      end
    end else begin
      case (cmd)
        CMD_OCTAVE: begin
          if (arg == ARG_DOWN)    octave_now = octave_now - 8'd1;
          else if (arg == ARG_UP) octave_now = octave_now + 8'd1;
          else                    octave_now = arg;
        end
        CMD_TEMPO:  tempo_now = arg;
        CMD_VOLUME: volume_now = arg[3:0];
        CMD_REST: begin
          r.action = ACT_REST;
          r.ticks  = wait_for_length(arg);
        end
        CMD_LOOP:   r.action = ACT_RESTART;
        default: ;  // unknown command: no effect
      endcase
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus build
  // --------------------------------------------------------------------------

  task automatic add_cmd(input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] arg,
                         input bit drain = 1'b0, input bit quiet = 1'b0);
    song_cmd_t c;
    c.command  = cmd;
    c.argument = arg;
    c.drain    = drain;
    c.quiet    = quiet;
    song_commands.push_back(c);
  endtask

  // Mostly playable songs: octaves kept in the table, short lengths; the rest
  // is full-range noise.
  task automatic add_random_song(input int count);
    int                r;
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] arg;
    bit                drain;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        cmd = BYTE_W'($urandom_range(0, 11));
        arg = ($urandom_range(0, 3) == 0) ? BYTE_W'($urandom_range(0, 255))
                                          : BYTE_W'($urandom_range(1, 16));
      end else if (r < 63) begin
        cmd = CMD_OCTAVE;
        case ($urandom_range(0, 9))
          0:       arg = ARG_DOWN;
          1:       arg = ARG_UP;
          2:       arg = BYTE_W'($urandom_range(0, 255));
          default: arg = BYTE_W'($urandom_range(3, 8));
        endcase
      end else if (r < 71) begin
        cmd = CMD_TEMPO;
        arg = BYTE_W'($urandom_range(0, 255));
      end else if (r < 77) begin
        cmd = CMD_VOLUME;
        arg = BYTE_W'($urandom_range(0, 255));
      end else if (r < 87) begin
        cmd = CMD_REST;
        arg = BYTE_W'($urandom_range(0, 255));
      end else if (r < 91) begin
        cmd = CMD_LOOP;
        arg = BYTE_W'($urandom_range(0, 255));
      end else begin
        cmd = BYTE_W'($urandom_range(0, 255));
        arg = BYTE_W'($urandom_range(0, 255));
      end
      // first random item and a few others wait for a fully drained block
      drain = (i == 0) || ($urandom_range(0, 199) == 0);
      add_cmd(cmd, arg, drain, i >= count - QUIET_ITEMS);
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: command channel, changes on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    song_cmd_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      // previous item gone (or none): pick what to offer next
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (song_commands.size() == 0) begin
        in_valid <= 1'b0;
      end else if (song_commands[0].drain && results_due.size() != 0) begin
        in_valid <= 1'b0;   // hold off until the block has emptied
      end else if (!calm && !song_commands[0].quiet && $urandom_range(0, 5) == 0) begin
        gap_left <= $urandom_range(0, 16);   // start a random idle gap
        in_valid <= 1'b0;
      end else begin
        c = song_commands.pop_front();
        in_command  <= c.command;
        in_argument <= c.argument;
        in_valid    <= 1'b1;
        if (c.quiet) calm <= 1'b1;
      end
    end
  end

  // Result channel back-pressure: stall bursts of random length.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 16);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: both handshakes sampled on the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    song_result_t exp_r;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready) results_due.push_back(play_command(in_command, in_argument));
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("result item with no command pending");
          mismatch_count++;
        end else begin
          exp_r = results_due.pop_front();
          if (out_action !== exp_r.action) begin
            $error("out_action: expected %0d, got %0d", exp_r.action, out_action);
            mismatch_count++;
          end
          if (out_envelope_value !== exp_r.envelope) begin
            $error("out_envelope_value: expected %0d, got %0d",
                   exp_r.envelope, out_envelope_value);
            mismatch_count++;
          end
          if (out_period_low !== exp_r.period_low) begin
            $error("out_period_low: expected %0d, got %0d",
                   exp_r.period_low, out_period_low);
            mismatch_count++;
          end
          if (out_period_high_trigger !== exp_r.period_high) begin
            $error("out_period_high_trigger: expected %0d, got %0d",
                   exp_r.period_high, out_period_high_trigger);
            mismatch_count++;
          end
          if (out_wait_ticks !== exp_r.ticks) begin
            $error("out_wait_ticks: expected %0d, got %0d", exp_r.ticks, out_wait_ticks);
            mismatch_count++;
          end
          if (out_index_fault !== exp_r.fault) begin
            $error("out_index_fault: expected %0d, got %0d", exp_r.fault, out_index_fault);
            mismatch_count++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    tone_period = '{
      11'd44,   11'd156,  11'd262,  11'd363,  11'd457,  11'd547,
      11'd631,  11'd710,  11'd786,  11'd854,  11'd923,  11'd986,
      11'd1046, 11'd1102, 11'd1155, 11'd1205, 11'd1253, 11'd1297,
      11'd1339, 11'd1379, 11'd1417, 11'd1452, 11'd1486, 11'd1517,
      11'd1546, 11'd1575, 11'd1602, 11'd1627, 11'd1650, 11'd1673,
      11'd1694, 11'd1714, 11'd1732, 11'd1750, 11'd1767, 11'd1783,
      11'd1798, 11'd1812, 11'd1825, 11'd1837, 11'd1849, 11'd1860,
      11'd1871, 11'd1881, 11'd1890, 11'd1899, 11'd1907, 11'd1915,
      11'd1923, 11'd1930, 11'd1936, 11'd1943, 11'd1949, 11'd1954,
      11'd1959, 11'd1964, 11'd1969, 11'd1974, 11'd1978, 11'd1982,
      11'd1985, 11'd1988, 11'd1992, 11'd1995, 11'd1998, 11'd2001,
      11'd2004, 11'd2006, 11'd2009, 11'd2011, 11'd2013, 11'd2015
    };
    octave_now = RESET_OCTAVE;
    tempo_now  = RESET_TEMPO;
    volume_now = RESET_VOLUME;

    // Directed: reset state, zero divisors, saturation, table edges.
    add_cmd(8'd0, 8'd1);                 // octave 4, tempo 60: wait 60
    add_cmd(8'd11, 8'd0);                // zero length -> 255
    add_cmd(CMD_OCTAVE, 8'd3);
    add_cmd(8'd0, 8'd255);               // first table entry
    add_cmd(CMD_TEMPO, 8'd0);
    add_cmd(8'd5, 8'd4);                 // zero tempo -> 255
    add_cmd(CMD_REST, 8'd7);
    add_cmd(CMD_TEMPO, 8'd1);
    add_cmd(8'd3, 8'd1);                 // 3600 saturates
    add_cmd(CMD_REST, 8'd0);
    add_cmd(CMD_TEMPO, 8'd255);
    add_cmd(8'd7, 8'd255);               // quotient 0
    add_cmd(CMD_OCTAVE, 8'd8);
    add_cmd(8'd11, 8'd2);                // last table entry
    add_cmd(CMD_OCTAVE, ARG_UP);
    add_cmd(8'd0, 8'd2);                 // one past the table
    add_cmd(CMD_OCTAVE, 8'd2);
    add_cmd(8'd11, 8'd2);                // negative index
    add_cmd(CMD_OCTAVE, 8'd0);
    add_cmd(CMD_OCTAVE, ARG_DOWN);       // wraps to 255
    add_cmd(8'd11, 8'd3);                // far out of table
    add_cmd(CMD_OCTAVE, ARG_UP);         // wraps back to 0
    add_cmd(CMD_VOLUME, 8'hff);          // only low nibble kept
    add_cmd(CMD_LOOP, 8'haa);
    add_cmd(CMD_UNKNOWN_HI, 8'h55);
    add_cmd(CMD_UNKNOWN_LO, 8'hff);

    add_random_song(RANDOM_ITEMS);

    // hold reset, then release it on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (song_commands.size() != 0 || in_valid) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);   // catch stray results

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
